FILE: hw/rtl/dsu_pkg.sv
// Shared constants for the disjoint-set union engine.
// No dependencies; used by the top level and by the RAM instance there.
package dsu_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = 10;

  // Input beat: first_node in [9:0], second_node in [19:10], zero pad to 24 bits.
  localparam int IN_DATA_W  = 24;
  // Output beat: merged in [0], representative in [10:1], zero pad to 16 bits.
  localparam int OUT_DATA_W = 16;

  typedef logic [NODE_W-1:0] node_t;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_COMP  = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  // Which find of the union sequence is running.
  localparam logic [1:0] OP_FIND_A   = 2'd0;
  localparam logic [1:0] OP_FIND_B   = 2'd1;
  localparam logic [1:0] OP_RECOMP_B = 2'd2;
  localparam logic [1:0] OP_RECOMP_A = 2'd3;

endpackage

FILE: hw/rtl/disjoint_set_union_engine.sv
// Top level of the disjoint-set union engine: sequencer around the parent table.
// Depends on dsu_pkg and dsu_ram.
//
// Usage: each input beat names two elements (first_node, second_node). The block
// finds both roots in the parent table, compresses both paths, and if the roots
// differ points the second root at the first. One output beat follows each input
// beat, giving the merge flag and the root of the first element's set.
//
// After reset the block sweeps the 1024-entry parent table, writing each entry
// with its own index; in_tready stays low meanwhile.
//
// Operation: one table read per hop. A find runs a start step, a walk to the root
// and a compression walk. A beat runs the finds of both elements, plus a repeat
// find of each when a merge happens, plus acceptance and the result hand-off.
// Only one beat is in work at a time.
//
// The result sits in an output register; the block is ready again as soon as
// it has moved its result there, even when the receiver stalls. A new result
// waits inside the block until out_tready frees that register.
module disjoint_set_union_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dsu_pkg::IN_DATA_W-1:0]  in_tdata,   // [9:0] first_node, [19:10] second_node
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dsu_pkg::OUT_DATA_W-1:0] out_tdata   // [0] merged, [10:1] representative
);

  logic [2:0]     state_r, state_nxt;
  logic [1:0]     op_r, op_nxt;
  dsu_pkg::node_t a_r, a_nxt;
  dsu_pkg::node_t b_r, b_nxt;
  dsu_pkg::node_t node_r, node_nxt;
  dsu_pkg::node_t cur_r, cur_nxt;
  dsu_pkg::node_t root_r, root_nxt;
  dsu_pkg::node_t ra_r, ra_nxt;
  dsu_pkg::node_t clr_r, clr_nxt;
  logic           res_merged_r, res_merged_nxt;
  dsu_pkg::node_t res_rep_r, res_rep_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_merged_r, out_merged_nxt;
  dsu_pkg::node_t out_rep_r, out_rep_nxt;

  logic           ram_we;
  dsu_pkg::node_t ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  dsu_ram #(
    .WIDTH (dsu_pkg::NODE_W),
    .DEPTH (dsu_pkg::NODES)
  ) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == dsu_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dsu_pkg::OUT_DATA_W - dsu_pkg::NODE_W - 1){1'b0}},
                       out_rep_r, out_merged_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    node_nxt       = node_r;
    cur_nxt        = cur_r;
    root_nxt       = root_r;
    ra_nxt         = ra_r;
    clr_nxt        = clr_r;
    res_merged_nxt = res_merged_r;
    res_rep_nxt    = res_rep_r;
    out_valid_nxt  = out_valid_r;
    out_merged_nxt = out_merged_r;
    out_rep_nxt    = out_rep_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = root_r;
    ram_raddr      = cur_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dsu_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == dsu_pkg::NODE_W'(dsu_pkg::NODES - 1)) begin
          state_nxt = dsu_pkg::S_IDLE;
        end
      end
      dsu_pkg::S_IDLE: begin
        if (in_tvalid) begin
          a_nxt     = in_tdata[dsu_pkg::NODE_W-1:0];
          b_nxt     = in_tdata[2*dsu_pkg::NODE_W-1:dsu_pkg::NODE_W];
          node_nxt  = in_tdata[dsu_pkg::NODE_W-1:0];
          op_nxt    = dsu_pkg::OP_FIND_A;
          state_nxt = dsu_pkg::S_START;
        end
      end
      dsu_pkg::S_START: begin
        ram_raddr = node_r;
        cur_nxt   = node_r;
        state_nxt = dsu_pkg::S_WALK;
      end
      dsu_pkg::S_WALK: begin
        // ram_rdata holds the parent of cur_r; a self pointer marks the root.
        if (ram_rdata == cur_r) begin
          root_nxt  = cur_r;
          ram_raddr = node_r;
          cur_nxt   = node_r;
          state_nxt = dsu_pkg::S_COMP;
        end else begin
          ram_raddr = ram_rdata;
          cur_nxt   = ram_rdata;
        end
      end
      dsu_pkg::S_COMP: begin
        if (cur_r != root_r) begin
          // Repoint this node at the root and move on to its old parent.
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = root_r;
          ram_raddr = ram_rdata;
          cur_nxt   = ram_rdata;
        end else begin
          unique case (op_r)
            dsu_pkg::OP_FIND_A: begin
              ra_nxt    = root_r;
              node_nxt  = b_r;
              op_nxt    = dsu_pkg::OP_FIND_B;
              state_nxt = dsu_pkg::S_START;
            end
            dsu_pkg::OP_FIND_B: begin
              if (root_r == ra_r) begin
                res_merged_nxt = 1'b0;
                res_rep_nxt    = ra_r;
                state_nxt      = dsu_pkg::S_HOLD;
              end else begin
                // Link the second root under the first, then walk both paths again.
                ram_we    = 1'b1;
                ram_waddr = root_r;
                ram_wdata = ra_r;
                node_nxt  = b_r;
                op_nxt    = dsu_pkg::OP_RECOMP_B;
                state_nxt = dsu_pkg::S_START;
              end
            end
            dsu_pkg::OP_RECOMP_B: begin
              node_nxt  = a_r;
              op_nxt    = dsu_pkg::OP_RECOMP_A;
              state_nxt = dsu_pkg::S_START;
            end
            dsu_pkg::OP_RECOMP_A: begin
              res_merged_nxt = 1'b1;
              res_rep_nxt    = root_r;
              state_nxt      = dsu_pkg::S_HOLD;
            end
            default: begin
              state_nxt = dsu_pkg::S_IDLE;
            end
          endcase
        end
      end
      dsu_pkg::S_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_merged_nxt = res_merged_r;
          out_rep_nxt    = res_rep_r;
          state_nxt      = dsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dsu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsu_pkg::S_CLEAR;
      op_r        <= dsu_pkg::OP_FIND_A;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    node_r       <= node_nxt;
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    ra_r         <= ra_nxt;
    res_merged_r <= res_merged_nxt;
    res_rep_r    <= res_rep_nxt;
    out_merged_r <= out_merged_nxt;
    out_rep_r    <= out_rep_nxt;
  end

endmodule

FILE: hw/rtl/dsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dsu_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for disjoint_set_union_engine: a union-find predictor
// tracks the parent table and checks every output beat. Depends on dsu_pkg.
`timescale 1ns / 1ps

module testbench;
  import dsu_pkg::*;

  typedef struct packed {
    logic  merged;
    node_t root;
  } union_result_t;

  typedef struct {
    node_t         first;
    node_t         second;
    bit            typed;
    union_result_t result;
  } union_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  localparam int RANDOM_UNIONS = 550;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  node_t         parent_of [NODES];
  union_result_t pending_unions [$];
  union_result_t oldest;
  int            mismatches = 0;
  int            burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_stretch = 0;
  int       rx_period = 2;
  int       rx_tick = 0;

  disjoint_set_union_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  // Walks to the root, then points every node on the way straight at it.
  function automatic node_t find_and_compress(input node_t node);
    node_t root;
    node_t cur;
    node_t nxt;
    int    hops;
    root = node;
    hops = 0;
    while (parent_of[root] != root && hops < NODES) begin
      root = parent_of[root];
      hops++;
    end
    cur = node;
    hops = 0;
    while (cur != root && hops < NODES) begin
      nxt = parent_of[cur];
      parent_of[cur] = root;
      cur = nxt;
      hops++;
    end
    return root;
  endfunction

  function automatic union_result_t predict_union(input node_t a, input node_t b);
    node_t         ra;
    node_t         rb;
    union_result_t res;
    ra = find_and_compress(a);
    rb = find_and_compress(b);
    if (ra == rb) begin
      res.merged = 1'b0;
      res.root   = ra;
    end else begin
      parent_of[rb] = ra;
      void'(find_and_compress(b));
      res.merged = 1'b1;
      res.root   = find_and_compress(a);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sends one beat; when a burst runs out, it usually inserts a random gap first.
  task automatic send_union(input node_t a, input node_t b, input bit typed,
                            input union_result_t typed_res);
    union_result_t predicted;
    int            gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_DATA_W - 2 * NODE_W){1'b0}}, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_union(a, b);
    pending_unions.push_back(typed ? typed_res : predicted);
    burst_left--;
  endtask

  task automatic drain_pending();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_unions.size() != 0) @(posedge clk);
  endtask

  // The receiver cycles through stretches of open, random and periodic stalls.
  always @(negedge clk) begin
    if (rx_stretch == 0) begin
      rx_stretch <= $urandom_range(20, 200);
      rx_mode    <= rx_mode_t'($urandom_range(0, 2));
      rx_period  <= $urandom_range(2, 8);
      rx_tick    <= 0;
    end else begin
      rx_stretch <= rx_stretch - 1;
      rx_tick    <= rx_tick + 1;
    end
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
      default:     out_tready <= (rx_tick % rx_period == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_unions.size() == 0) begin
        report_mismatch("unexpected beat, out_tdata", int'(out_tdata), 0);
      end else begin
        oldest = pending_unions.pop_front();
        if (out_tdata[0] !== oldest.merged)
          report_mismatch("merged", int'(out_tdata[0]), int'(oldest.merged));
        if (out_tdata[NODE_W:1] !== oldest.root)
          report_mismatch("representative", int'(out_tdata[NODE_W:1]), int'(oldest.root));
      end
    end
  end

  initial begin
    union_row_t    directed [$];
    node_t         recent [16];
    node_t         a;
    node_t         b;
    node_t         last_first;
    union_result_t none;
    int            sel;

    for (int i = 0; i < NODES; i++) parent_of[i] = node_t'(i);
    for (int i = 0; i < 16; i++) recent[i] = node_t'(i);
    none = '0;
    last_first = '0;

    // Rows with a typed result follow from a fresh table; the rest use the predictor.
    directed = '{
      '{10'd5,    10'd5,    1'b1, '{1'b0, 10'd5}},
      '{10'd0,    10'd1023, 1'b1, '{1'b1, 10'd0}},
      '{10'd1023, 10'd0,    1'b1, '{1'b0, 10'd0}},
      '{10'd1023, 10'd1023, 1'b1, '{1'b0, 10'd0}},
      '{10'd682,  10'd341,  1'b1, '{1'b1, 10'd682}},
      '{10'd341,  10'd682,  1'b1, '{1'b0, 10'd682}},
      // Each new first element takes over the previous root: a chain from 10 up to 16.
      '{10'd11,   10'd10,   1'b1, '{1'b1, 10'd11}},
      '{10'd12,   10'd11,   1'b1, '{1'b1, 10'd12}},
      '{10'd13,   10'd12,   1'b1, '{1'b1, 10'd13}},
      '{10'd14,   10'd13,   1'b1, '{1'b1, 10'd14}},
      '{10'd15,   10'd14,   1'b1, '{1'b1, 10'd15}},
      '{10'd16,   10'd15,   1'b1, '{1'b1, 10'd16}},
      '{10'd10,   10'd1023, 1'b0, '{1'b0, 10'd0}},
      '{10'd1023, 10'd10,   1'b0, '{1'b0, 10'd0}},
      '{10'd0,    10'd0,    1'b0, '{1'b0, 10'd0}},
      '{10'd20,   10'd21,   1'b0, '{1'b0, 10'd0}},
      '{10'd22,   10'd20,   1'b0, '{1'b0, 10'd0}},
      '{10'd21,   10'd22,   1'b0, '{1'b0, 10'd0}},
      '{10'd21,   10'd682,  1'b0, '{1'b0, 10'd0}},
      '{10'd341,  10'd12,   1'b0, '{1'b0, 10'd0}}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_union(directed[i].first, directed[i].second, directed[i].typed,
                 directed[i].result);

    for (int n = 0; n < RANDOM_UNIONS; n++) begin
      if (n == RANDOM_UNIONS / 2) drain_pending();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        a = node_t'($urandom_range(0, 63));
        b = node_t'($urandom_range(0, 63));
      end else if (sel < 50) begin
        a = node_t'($urandom_range(0, NODES - 1));
        b = a;
      end else if (sel < 65) begin
        a = recent[$urandom_range(0, 15)];
        b = recent[$urandom_range(0, 15)];
      end else if (sel < 80) begin
        // A fresh first element absorbs the previous one, which deepens chains.
        a = node_t'($urandom_range(0, NODES - 1));
        b = last_first;
      end else begin
        a = node_t'($urandom_range(0, NODES - 1));
        b = node_t'($urandom_range(0, NODES - 1));
      end
      recent[$urandom_range(0, 15)] = a;
      recent[$urandom_range(0, 15)] = b;
      last_first = a;
      send_union(a, b, 1'b0, none);
    end

    drain_pending();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
